// ===== sv/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg: shared types and constants of the motor fault supervisor
// motor count, field widths, register codes, reset values and lane structs
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int MOTOR_COUNT = 3;
  localparam int NMOT        = (MOTOR_COUNT < 3) ? MOTOR_COUNT : 3;
  localparam int NPIN        = 3;

  localparam int CNT_W      = 17;
  localparam int LIM_W      = 16;
  localparam int STEP_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [NPIN-1:0] MOTOR_MASK = NPIN'((1 << NMOT) - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UV_LIMIT  = 8'd0,
    CFG_OV_LIMIT  = 8'd1,
    CFG_OC_LIMIT  = 8'd2,
    CFG_TRIP_TIME = 8'd3,
    CFG_VOLT_RISE = 8'd4,
    CFG_VOLT_FALL = 8'd5,
    CFG_CUR_RISE  = 8'd6,
    CFG_CUR_FALL  = 8'd7
  } cfg_reg_t;

  localparam logic [LIM_W-1:0]  UV_LIMIT_RST  = 16'd10000;
  localparam logic [LIM_W-1:0]  OV_LIMIT_RST  = 16'd30000;
  localparam logic [LIM_W-1:0]  OC_LIMIT_RST  = 16'd10000;
  localparam logic [LIM_W-1:0]  TRIP_TIME_RST = 16'd100;
  localparam logic [STEP_W-1:0] STEP_RST      = 8'd1;

  // per-lane control, shared by the voltage lane and the current lanes
  typedef struct packed {
    logic              step;
    logic              preset;
    logic              skip;
    logic [CNT_W-1:0]  pre;
    logic [LIM_W-1:0]  trip;
    logic [STEP_W-1:0] rise;
    logic [STEP_W-1:0] fall;
  } lane_ctl_t;

  typedef struct packed {
    logic hit;
    logic flag;
  } lane_res_t;

  // tick-level flags handed to the merging stage
  typedef struct packed {
    logic [NPIN-1:0] drv;
    logic            pre_hit;
    logic            enabled;
    logic            skip;
    logic            pending;
    logic            autor;
    logic            pkt;
    logic            err;
  } tick_flags_t;

  typedef struct packed {
    logic            disable_output;
    logic            error_latched;
    logic            voltage_fault;
    logic [NPIN-1:0] current_faults;
    logic [NPIN-1:0] driver_faults;
    logic            any_error;
    logic            request_reset;
  } mfs_res_t;

endpackage

// ===== sv/mfs_in_if.sv =====
// ----------------------------------------------------------------------------
// mfs_in_if: tick request channel
// valid/ready channel carrying one supervision tick
// ----------------------------------------------------------------------------
interface mfs_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         fault_pins_n;
  logic [15:0]        bus_voltage;
  logic signed [15:0] current_a;
  logic signed [15:0] current_b;
  logic signed [15:0] current_c;
  logic               output_enabled;
  logic               ignore_errors;
  logic               initializing;
  logic               reset_pending;
  logic               auto_reset_enabled;
  logic               packet_error;

  modport source (
    output valid, fault_pins_n, bus_voltage, current_a, current_b, current_c,
           output_enabled, ignore_errors, initializing, reset_pending,
           auto_reset_enabled, packet_error,
    input  ready
  );
  modport sink (
    input  valid, fault_pins_n, bus_voltage, current_a, current_b, current_c,
           output_enabled, ignore_errors, initializing, reset_pending,
           auto_reset_enabled, packet_error,
    output ready
  );
endinterface

// ===== sv/mfs_out_if.sv =====
// ----------------------------------------------------------------------------
// mfs_out_if: supervision result channel
// valid/ready channel carrying one result per tick
// ----------------------------------------------------------------------------
interface mfs_out_if;
  logic       valid;
  logic       ready;
  logic       disable_output;
  logic       error_latched;
  logic       voltage_fault;
  logic [2:0] current_faults;
  logic [2:0] driver_faults;
  logic       any_error;
  logic       request_reset;

  modport source (
    output valid, disable_output, error_latched, voltage_fault, current_faults,
           driver_faults, any_error, request_reset,
    input  ready
  );
  modport sink (
    input  valid, disable_output, error_latched, voltage_fault, current_faults,
           driver_faults, any_error, request_reset,
    output ready
  );
endinterface

// ===== sv/mfs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mfs_cfg_if: configuration write channel
// valid/ready channel carrying a register index and write data
// ----------------------------------------------------------------------------
interface mfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/mfs_lane.sv =====
// ----------------------------------------------------------------------------
// mfs_lane: leaky-bucket fault lane
// one counter with its trip flag, preset on driver fault, floored at zero
// ----------------------------------------------------------------------------
module mfs_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  mfs_pkg::lane_ctl_t ctl,
  input  logic               bad,
  output mfs_pkg::lane_res_t res
);
  import mfs_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] base, stepped, trip_x, fall_x;
  logic             flag_r, flag_nxt;

  always_comb begin
    trip_x  = CNT_W'(ctl.trip);
    fall_x  = CNT_W'(ctl.fall);
    base    = ctl.preset ? ctl.pre : cnt_r;
    stepped = base;
    if (bad) begin
      if (base < trip_x) stepped = base + CNT_W'(ctl.rise);
    end else if (base > fall_x) begin
      stepped = base - fall_x;
    end else begin
      stepped = '0;
    end
    cnt_nxt  = ctl.skip ? base : stepped;
    res.hit  = !ctl.skip && (stepped >= trip_x);
    flag_nxt = flag_r;
    if (!ctl.skip) begin
      if (stepped >= trip_x) flag_nxt = 1'b1;
      else if (stepped == '0) flag_nxt = 1'b0;
    end
    res.flag = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      flag_r <= 1'b0;
    end else if (ctl.step) begin
      cnt_r  <= cnt_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

// ===== sv/mfs_merge.sv =====
// ----------------------------------------------------------------------------
// mfs_merge: merging stage of the fault lanes
// combines lane trips with driver faults into the tick result
// ----------------------------------------------------------------------------
module mfs_merge (
  input  mfs_pkg::lane_res_t   vres,
  input  mfs_pkg::lane_res_t   cres [mfs_pkg::NMOT],
  input  mfs_pkg::tick_flags_t tf,
  output mfs_pkg::mfs_res_t    res
);
  import mfs_pkg::*;

  logic [NPIN-1:0] cflags;
  logic            trip_any;
  logic            dis;
  logic            en_after;
  logic            any;

  always_comb begin
    cflags   = '0;
    trip_any = vres.hit;
    for (int i = 0; i < NMOT; i++) begin
      cflags[i] = cres[i].flag;
      trip_any  = trip_any | cres[i].hit;
    end
    dis      = tf.pre_hit | trip_any;
    en_after = tf.enabled & ~dis;
    any      = (|tf.drv) | (|cflags) | vres.flag | tf.pkt;

    res.disable_output = dis;
    res.error_latched  = tf.err | dis;
    res.voltage_fault  = vres.flag;
    res.current_faults = cflags;
    res.driver_faults  = tf.drv;
    res.any_error      = any;
    res.request_reset  = tf.pending |
                         (!tf.skip && !en_after && !any && tf.autor);
  end

endmodule

// ===== sv/motor_fault_supervisor.sv =====
// ----------------------------------------------------------------------------
// motor_fault_supervisor: per-tick fault supervisor for a motor driver board
// result: registered, loaded when a tick request is accepted
// throughput: 1 tick per cycle while the result channel is not stalled
// reset: synchronous rst_n clears counters, flags and error, loads register defaults
// ----------------------------------------------------------------------------
module motor_fault_supervisor (
  input logic   clk,
  input logic   rst_n,
  mfs_in_if.sink    in_ch,
  mfs_out_if.source out_ch,
  mfs_cfg_if.sink   cfg_ch
);
  import mfs_pkg::*;

  // configuration registers
  logic [LIM_W-1:0]  uv_lim_r, ov_lim_r, trip_r;
  logic signed [LIM_W-1:0] oc_lim_r;
  logic [STEP_W-1:0] vrise_r, vfall_r, crise_r, cfall_r;

  // sticky error and output stage
  logic     err_r;
  logic     out_valid_r;
  mfs_res_t out_r;

  logic        accept;
  logic [NPIN-1:0] drv;
  logic        pre_hit;
  logic        skip;
  logic [CNT_W-1:0] pre;
  logic signed [LIM_W-1:0] cur [NPIN];
  logic        vbad;
  logic [NMOT-1:0] cbad;
  lane_ctl_t   vctl, cctl;
  lane_res_t   vres;
  lane_res_t   cres [NMOT];
  tick_flags_t tf;
  mfs_res_t    res;

  // config writes are always taken; unknown indexes fall through
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_lim_r <= UV_LIMIT_RST;
      ov_lim_r <= OV_LIMIT_RST;
      oc_lim_r <= OC_LIMIT_RST;
      trip_r   <= TRIP_TIME_RST;
      vrise_r  <= STEP_RST;
      vfall_r  <= STEP_RST;
      crise_r  <= STEP_RST;
      cfall_r  <= STEP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        CFG_UV_LIMIT:  uv_lim_r <= cfg_ch.data;
        CFG_OV_LIMIT:  ov_lim_r <= cfg_ch.data;
        CFG_OC_LIMIT:  oc_lim_r <= cfg_ch.data;
        CFG_TRIP_TIME: trip_r   <= cfg_ch.data;
        CFG_VOLT_RISE: vrise_r  <= cfg_ch.data[STEP_W-1:0];
        CFG_VOLT_FALL: vfall_r  <= cfg_ch.data[STEP_W-1:0];
        CFG_CUR_RISE:  crise_r  <= cfg_ch.data[STEP_W-1:0];
        CFG_CUR_FALL:  cfall_r  <= cfg_ch.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // take a new tick whenever the output register is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // driver fault pins are active low; only populated motors count
  assign drv     = ~in_ch.fault_pins_n & MOTOR_MASK;
  assign pre_hit = (|drv) && in_ch.output_enabled;
  assign skip    = in_ch.ignore_errors | in_ch.initializing;
  // preset level one below trip, or zero when trip time is zero
  assign pre     = (trip_r == '0) ? '0 : CNT_W'(trip_r) - CNT_W'(1);

  assign cur[0] = in_ch.current_a;
  assign cur[1] = in_ch.current_b;
  assign cur[2] = in_ch.current_c;

  // bus window check
  assign vbad = (in_ch.bus_voltage < uv_lim_r) || (in_ch.bus_voltage > ov_lim_r);

  always_comb begin
    vctl.step   = accept;
    vctl.preset = pre_hit;
    vctl.skip   = skip;
    vctl.pre    = pre;
    vctl.trip   = trip_r;
    vctl.rise   = vrise_r;
    vctl.fall   = vfall_r;
    cctl        = vctl;
    cctl.rise   = crise_r;
    cctl.fall   = cfall_r;
  end

  // voltage lane
  mfs_lane u_vlane (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (vctl),
    .bad   (vbad),
    .res   (vres)
  );

  // one over-current lane per motor, side by side
  for (genvar g = 0; g < NMOT; g++) begin : g_clane
    assign cbad[g] = cur[g] > oc_lim_r;
    mfs_lane u_clane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cctl),
      .bad   (cbad[g]),
      .res   (cres[g])
    );
  end

  always_comb begin
    tf.drv     = drv;
    tf.pre_hit = pre_hit;
    tf.enabled = in_ch.output_enabled;
    tf.skip    = skip;
    tf.pending = in_ch.reset_pending;
    tf.autor   = in_ch.auto_reset_enabled;
    tf.pkt     = in_ch.packet_error;
    tf.err     = err_r;
  end

  mfs_merge u_merge (
    .vres (vres),
    .cres (cres),
    .tf   (tf),
    .res  (res)
  );

  // sticky error and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        err_r       <= res.error_latched;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_r <= res;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.disable_output = out_r.disable_output;
  assign out_ch.error_latched  = out_r.error_latched;
  assign out_ch.voltage_fault  = out_r.voltage_fault;
  assign out_ch.current_faults = out_r.current_faults;
  assign out_ch.driver_faults  = out_r.driver_faults;
  assign out_ch.any_error      = out_r.any_error;
  assign out_ch.request_reset  = out_r.request_reset;

`ifndef SYNTHESIS
  // once latched, the error flag only goes away with reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("error flag dropped without reset");

  // a disable request always comes with the latched error
  a_dis_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.disable_output) |-> out_r.error_latched)
    else $error("disable without latched error");

  // any active fault flag shows up in the summary bit
  a_any_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.voltage_fault || (out_r.current_faults != '0) ||
     (out_r.driver_faults != '0))) |-> out_r.any_error)
    else $error("fault flag without any_error");
`endif

endmodule

// ===== tb/sv/motor_fault_supervisor_tb.sv =====
// ----------------------------------------------------------------------------
// motor_fault_supervisor_tb: self-checking regression of the fault supervisor
// drives tick requests and register writes, mirrors the leaky-bucket counters,
// trip flags and reset logic in a behavioral copy, checks every result field
// ----------------------------------------------------------------------------
module motor_fault_supervisor_tb;
  import mfs_pkg::*;

  // registered result behind the tick request
  localparam int LATENCY       = 1;
  localparam int SETTLE_CYCLES = LATENCY + 3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PCT      = 21;
  // index outside the register map, the write must leave every register alone
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFF;

  // one supervision tick as the source side sees it
  typedef struct packed {
    logic [2:0]         fault_pins_n;
    logic [15:0]        bus_voltage;
    logic signed [15:0] current_a;
    logic signed [15:0] current_b;
    logic signed [15:0] current_c;
    logic               output_enabled;
    logic               ignore_errors;
    logic               initializing;
    logic               reset_pending;
    logic               auto_reset_enabled;
    logic               packet_error;
  } tick_t;

  logic clk;
  logic rst_n;

  mfs_in_if  in_ch ();
  mfs_out_if out_ch ();
  mfs_cfg_if cfg_ch ();

  motor_fault_supervisor i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow copy of the register file
  logic [15:0]        uv_limit;
  logic [15:0]        ov_limit;
  logic signed [15:0] oc_limit;
  logic [15:0]        trip_time;
  logic [7:0]         volt_rise;
  logic [7:0]         volt_fall;
  logic [7:0]         amp_rise;
  logic [7:0]         amp_fall;

  // shadow copy of the supervisor state
  logic [CNT_W-1:0] volt_count;
  logic [CNT_W-1:0] amp_count [3];
  logic             volt_flag;
  logic [2:0]       amp_flags;
  logic             err_flag;

  tick_t    tick_backlog [$];
  mfs_res_t expected_reports [$];
  tick_t    tick_on_bus;
  mfs_res_t report;
  mfs_res_t want;
  int       mismatches;
  int       cycle_count;
  bit       steady;

  // clock; the single reset pulse comes from the main sequence
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // behavioral copy of the supervisor
  // ---------------------------------------------------------------------------

  // leaky bucket: rises only below the trip level, drains with a floor at zero
  function automatic logic [CNT_W-1:0] bucket_next(logic [CNT_W-1:0] cnt, logic bad,
                                                   logic [7:0] rise, logic [7:0] fall);
    if (bad) return (cnt < {1'b0, trip_time}) ? cnt + CNT_W'(rise) : cnt;
    if (cnt > CNT_W'(fall)) return cnt - CNT_W'(fall);
    return '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      CFG_UV_LIMIT:  uv_limit  = val;
      CFG_OV_LIMIT:  ov_limit  = val;
      CFG_OC_LIMIT:  oc_limit  = val;
      CFG_TRIP_TIME: trip_time = val;
      CFG_VOLT_RISE: volt_rise = val[7:0];
      CFG_VOLT_FALL: volt_fall = val[7:0];
      CFG_CUR_RISE:  amp_rise  = val[7:0];
      CFG_CUR_FALL:  amp_fall  = val[7:0];
      default: ;
    endcase
  endfunction

  task automatic supervise_tick(input tick_t t, output mfs_res_t r);
    logic [2:0]         drv;
    logic               enabled;
    logic               skip;
    logic               cut_output;
    logic               any;
    logic               req;
    logic               vbad;
    logic [CNT_W-1:0]   preset;
    logic signed [15:0] amps [3];
    drv        = ~t.fault_pins_n & MOTOR_MASK;
    enabled    = t.output_enabled;
    skip       = t.ignore_errors | t.initializing;
    cut_output = 1'b0;
    amps[0]    = t.current_a;
    amps[1]    = t.current_b;
    amps[2]    = t.current_c;

    // driver fault while running: shut off and park every counter just below trip
    if (drv != '0 && enabled) begin
      preset     = (trip_time != '0) ? {1'b0, trip_time} - 1'b1 : '0;
      cut_output = 1'b1;
      enabled    = 1'b0;
      err_flag   = 1'b1;
      volt_count = preset;
      for (int i = 0; i < NMOT; i++) amp_count[i] = preset;
    end

    if (!skip) begin
      vbad       = t.bus_voltage < uv_limit || t.bus_voltage > ov_limit;
      volt_count = bucket_next(volt_count, vbad, volt_rise, volt_fall);
      for (int i = 0; i < NMOT; i++)
        amp_count[i] = bucket_next(amp_count[i], amps[i] > oc_limit, amp_rise, amp_fall);

      if (volt_count >= {1'b0, trip_time}) begin
        cut_output = 1'b1;
        enabled    = 1'b0;
        err_flag   = 1'b1;
        volt_flag  = 1'b1;
      end else if (volt_count == '0) begin
        volt_flag = 1'b0;
      end
      for (int i = 0; i < NMOT; i++) begin
        if (amp_count[i] >= {1'b0, trip_time}) begin
          cut_output   = 1'b1;
          enabled      = 1'b0;
          err_flag     = 1'b1;
          amp_flags[i] = 1'b1;
        end else if (amp_count[i] == '0) begin
          amp_flags[i] = 1'b0;
        end
      end
    end

    any = drv != '0 || amp_flags != '0 || volt_flag || t.packet_error;
    // auto recovery only when evaluated, off and quiet; a pending reset passes straight through
    req = t.reset_pending ||
          (!skip && !enabled && !any && t.auto_reset_enabled);

    r.disable_output = cut_output;
    r.error_latched  = err_flag;
    r.voltage_fault  = volt_flag;
    r.current_faults = amp_flags;
    r.driver_faults  = drv;
    r.any_error      = any;
    r.request_reset  = req;
  endtask

  // ---------------------------------------------------------------------------
  // tick driver: pops the backlog, predicts each request as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        supervise_tick(tick_on_bus, report);
        expected_reports.push_back(report);
      end
      // payload only moves once the current request is gone
      if (!in_ch.valid || in_ch.ready) begin
        if (tick_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          tick_on_bus = tick_backlog.pop_front();
          in_ch.fault_pins_n       <= tick_on_bus.fault_pins_n;
          in_ch.bus_voltage        <= tick_on_bus.bus_voltage;
          in_ch.current_a          <= tick_on_bus.current_a;
          in_ch.current_b          <= tick_on_bus.current_b;
          in_ch.current_c          <= tick_on_bus.current_c;
          in_ch.output_enabled     <= tick_on_bus.output_enabled;
          in_ch.ignore_errors      <= tick_on_bus.ignore_errors;
          in_ch.initializing       <= tick_on_bus.initializing;
          in_ch.reset_pending      <= tick_on_bus.reset_pending;
          in_ch.auto_reset_enabled <= tick_on_bus.auto_reset_enabled;
          in_ch.packet_error       <= tick_on_bus.packet_error;
          in_ch.valid              <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random back-pressure, in-order field compare
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned exp_val, int unsigned got);
    if (exp_val != got) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result with no tick request outstanding");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("disable_output", want.disable_output, out_ch.disable_output);
          check_field("error_latched", want.error_latched, out_ch.error_latched);
          check_field("voltage_fault", want.voltage_fault, out_ch.voltage_fault);
          check_field("current_faults", want.current_faults, out_ch.current_faults);
          check_field("driver_faults", want.driver_faults, out_ch.driver_faults);
          check_field("any_error", want.any_error, out_ch.any_error);
          check_field("request_reset", want.request_reset, out_ch.request_reset);
        end
      end
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("motor_fault_supervisor regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // flags: {output_enabled, ignore_errors, initializing, reset_pending,
  //         auto_reset_enabled, packet_error}
  function automatic tick_t mk_tick(logic [2:0] pins, logic [15:0] vbus, logic [15:0] ia,
                                    logic [15:0] ib, logic [15:0] ic, logic [5:0] flags);
    tick_t t;
    t.fault_pins_n       = pins;
    t.bus_voltage        = vbus;
    t.current_a          = ia;
    t.current_b          = ib;
    t.current_c          = ic;
    t.output_enabled     = flags[5];
    t.ignore_errors      = flags[4];
    t.initializing       = flags[3];
    t.reset_pending      = flags[2];
    t.auto_reset_enabled = flags[1];
    t.packet_error       = flags[0];
    return t;
  endfunction

  // bus sample inside or outside the window, with some boundaries and noise
  function automatic logic [15:0] pick_volts(bit bad);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 16'($urandom);
    if (r == 1) begin
      case ($urandom_range(3))
        0: return uv_limit;
        1: return uv_limit - 1'b1;
        2: return ov_limit;
        default: return ov_limit + 1'b1;
      endcase
    end
    if (bad) begin
      if (uv_limit != '0 && (ov_limit == 16'hFFFF || $urandom_range(1) == 0))
        return 16'($urandom_range(uv_limit - 1));
      if (ov_limit != 16'hFFFF) return 16'($urandom_range(65535, ov_limit + 1));
      return 16'($urandom);
    end
    if (uv_limit <= ov_limit) return 16'($urandom_range(ov_limit, uv_limit));
    return 16'($urandom);
  endfunction

  // motor current above or at/below the over-current limit
  function automatic logic [15:0] pick_amps(bit bad);
    int          lim;
    int unsigned r;
    lim = int'(oc_limit);
    r   = $urandom_range(9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return ($urandom_range(1) == 0) ? 16'(lim) : 16'(lim + 1);
    if (bad && lim < 32767) return 16'(int'($urandom_range(32767 - lim - 1)) + lim + 1);
    if (!bad) return 16'(lim - int'($urandom_range(lim + 32768)));
    return 16'($urandom);
  endfunction

  // random ticks in segments: runs of faulty or healthy samples so the buckets
  // actually fill up, trip, and drain back to zero
  task automatic queue_random_ticks(int count);
    int    seg_left;
    int    volt_pct;
    int    amp_pct [3];
    int    drv_pct;
    tick_t t;
    seg_left = 0;
    for (int n = 0; n < count; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 4);
        case ($urandom_range(3))
          0: volt_pct = 0;
          1: volt_pct = 100;
          2: volt_pct = 50;
          default: volt_pct = $urandom_range(100);
        endcase
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(3))
            0: amp_pct[i] = 0;
            1: amp_pct[i] = 100;
            default: amp_pct[i] = $urandom_range(100);
          endcase
        end
        drv_pct = ($urandom_range(3) == 0) ? 30 : 3;
      end
      seg_left--;
      t.fault_pins_n = ($urandom_range(99) < drv_pct) ? 3'($urandom_range(6)) : 3'b111;
      t.bus_voltage  = pick_volts($urandom_range(99) < volt_pct);
      t.current_a    = pick_amps($urandom_range(99) < amp_pct[0]);
      t.current_b    = pick_amps($urandom_range(99) < amp_pct[1]);
      t.current_c    = pick_amps($urandom_range(99) < amp_pct[2]);
      t.output_enabled     = $urandom_range(99) < 75;
      t.ignore_errors      = $urandom_range(99) < 8;
      t.initializing       = $urandom_range(99) < 8;
      t.reset_pending      = $urandom_range(99) < 20;
      t.auto_reset_enabled = $urandom_range(99) < 60;
      t.packet_error       = $urandom_range(99) < 12;
      tick_backlog.push_back(t);
    end
  endtask

  // block is idle once nothing is queued, on the bus or still owed
  task automatic wait_idle();
    do @(negedge clk);
    while (tick_backlog.size() != 0 || in_ch.valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // keeps valid high across back-to-back writes, caller lowers it afterwards
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    apply_reg(idx, val);
  endtask

  task automatic load_settings(logic [15:0] uv, logic [15:0] ov, logic [15:0] oc,
                               logic [15:0] trip, logic [7:0] vr, logic [7:0] vf,
                               logic [7:0] ar, logic [7:0] af);
    cfg_write(CFG_UV_LIMIT, uv);
    cfg_write(CFG_OV_LIMIT, ov);
    cfg_write(CFG_OC_LIMIT, oc);
    cfg_write(CFG_TRIP_TIME, trip);
    cfg_write(CFG_VOLT_RISE, 16'(vr));
    cfg_write(CFG_VOLT_FALL, 16'(vf));
    cfg_write(CFG_CUR_RISE, 16'(ar));
    cfg_write(CFG_CUR_FALL, 16'(af));
    // stray index, must not disturb anything
    cfg_write(CFG_IDX_UNUSED, 16'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_step();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255, 1)) : 8'($urandom_range(6, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] uv;
    logic [15:0] ov;
    logic [15:0] oc;
    logic [15:0] trip;

    // every input known from time zero
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.fault_pins_n       = 3'b111;
    in_ch.bus_voltage        = '0;
    in_ch.current_a          = '0;
    in_ch.current_b          = '0;
    in_ch.current_c          = '0;
    in_ch.output_enabled     = 1'b0;
    in_ch.ignore_errors      = 1'b0;
    in_ch.initializing       = 1'b0;
    in_ch.reset_pending      = 1'b0;
    in_ch.auto_reset_enabled = 1'b0;
    in_ch.packet_error       = 1'b0;
    out_ch.ready             = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = '0;
    cfg_ch.data              = '0;
    mismatches               = 0;
    cycle_count              = 0;
    steady                   = 1'b0;

    // reset values of registers and state
    uv_limit   = UV_LIMIT_RST;
    ov_limit   = OV_LIMIT_RST;
    oc_limit   = OC_LIMIT_RST;
    trip_time  = TRIP_TIME_RST;
    volt_rise  = STEP_RST;
    volt_fall  = STEP_RST;
    amp_rise   = STEP_RST;
    amp_fall   = STEP_RST;
    volt_count = '0;
    for (int i = 0; i < 3; i++) amp_count[i] = '0;
    volt_flag  = 1'b0;
    amp_flags  = '0;
    err_flag   = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed ticks at reset defaults (window 10000..30000, limit 10000, trip 100)
    // healthy and running
    tick_backlog.push_back(mk_tick(3'b111, 16'd20000, 16'd0, 16'd0, 16'd0, 6'b100000));
    // output off with auto reset: recovery request
    tick_backlog.push_back(mk_tick(3'b111, 16'd20000, 16'd0, 16'd0, 16'd0, 6'b000010));
    // pending reset passes straight through
    tick_backlog.push_back(mk_tick(3'b111, 16'd20000, 16'd0, 16'd0, 16'd0, 6'b000100));
    // packet error blocks recovery
    tick_backlog.push_back(mk_tick(3'b111, 16'd20000, 16'd0, 16'd0, 16'd0, 6'b000011));
    // evaluation skipped: no auto reset
    tick_backlog.push_back(mk_tick(3'b111, 16'd20000, 16'd0, 16'd0, 16'd0, 6'b010010));
    tick_backlog.push_back(mk_tick(3'b111, 16'd20000, 16'd0, 16'd0, 16'd0, 6'b001110));
    // field extremes
    tick_backlog.push_back(mk_tick(3'b111, 16'd0, 16'h8000, 16'h8000, 16'h8000, 6'b100000));
    tick_backlog.push_back(mk_tick(3'b111, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                   6'b100000));
    // exactly on the window edges and the current limit: healthy; one step over the limit is faulty
    tick_backlog.push_back(mk_tick(3'b111, 16'd10000, 16'd10000, 16'd10000, 16'd10000,
                                   6'b100000));
    tick_backlog.push_back(mk_tick(3'b111, 16'd30000, 16'd10001, 16'd0, 16'd0, 6'b100000));
    // driver fault while running presets the buckets
    tick_backlog.push_back(mk_tick(3'b110, 16'd20000, 16'd0, 16'd0, 16'd0, 6'b100000));
    tick_backlog.push_back(mk_tick(3'b101, 16'd9999, 16'd0, 16'd0, 16'd0, 6'b100000));
    // driver fault with output already off: no preset
    tick_backlog.push_back(mk_tick(3'b011, 16'd30001, 16'd10001, 16'd10001, 16'd10001,
                                   6'b000010));
    // every pin low with every lane faulty
    tick_backlog.push_back(mk_tick(3'b000, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 6'b100000));
    tick_backlog.push_back(mk_tick(3'b111, 16'd20000, 16'd0, 16'd0, 16'd0, 6'b010000));
    // driver fault while ignoring errors: preset happens, evaluation does not
    tick_backlog.push_back(mk_tick(3'b000, 16'd20000, 16'd0, 16'd0, 16'd0, 6'b110100));
    // latched faults hold off recovery
    tick_backlog.push_back(mk_tick(3'b111, 16'd20000, 16'd0, 16'd0, 16'd0, 6'b000010));
    queue_random_ticks(60);
    wait_idle();

    // limits at their minimum, trip time and steps at one
    load_settings(16'd0, 16'd0, 16'h8000, 16'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    queue_random_ticks(150);
    wait_idle();

    // all registers at their maximum
    load_settings(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255);
    queue_random_ticks(150);
    wait_idle();

    // trip level of zero: every evaluated bucket counts as tripped
    load_settings(16'($urandom_range(20000)), 16'($urandom_range(65535, 20000)),
                  16'($urandom_range(15000)), 16'd0, rand_step(), rand_step(),
                  rand_step(), rand_step());
    queue_random_ticks(120);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      uv = 16'($urandom_range(20000));
      ov = ($urandom_range(7) == 0) ? 16'($urandom) : 16'(uv + $urandom_range(30000));
      oc = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15000));
      trip = ($urandom_range(4) == 0) ? 16'($urandom_range(2000, 41))
                                      : 16'($urandom_range(40, 1));
      load_settings(uv, ov, oc, trip, rand_step(), rand_step(), rand_step(), rand_step());
      // one phase runs with both sides flat out
      steady = (p == 2);
      queue_random_ticks(180);
      wait_idle();
      steady = 1'b0;
    end

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("motor_fault_supervisor regression: pass");
    end else begin
      $display("motor_fault_supervisor regression: fail");
    end
    $finish;
  end

endmodule
